FILE: hdl/sslt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sslt_pkg;

    localparam logic [1:0] CMD_ATTACH = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_RETIRE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam int SLOT_OUT_W = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seq;
        logic [31:0] length;
        logic [2:0]  kind;
        logic [31:0] handle;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [2:0]            found_kind;
        logic [31:0]           found_handle;
        logic [31:0]           offset;
        logic [31:0]           remaining;
    } t_rsp;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [2:0]  kind;
        logic [31:0] token;
    } t_seg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RET,
        S_PUSH
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/send_segment_seq_lookup_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring of up to SEGMENT_SLOTS send segments held in one single-port-read memory.
// One request is worked at a time; o_req_stall is high from acceptance until
// the result has been loaded into the output register, which then holds it
// while the next request is taken. Attach and commands that do nothing go
// straight to the output register, retire makes one memory read first, and
// lookup examines segments up to the current fill (at most SEGMENT_SLOTS),
// stopping at the first hit: the memory read port and a single 32-bit
// subtract-and-compare unit check one segment per cycle, oldest first.
// Nothing needs clearing after reset.
module send_segment_seq_lookup_table
    import sslt_pkg::*;
#(
    parameter int SEGMENT_SLOTS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    localparam int AW = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
    localparam int CW = $clog2(SEGMENT_SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SEGMENT_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(SEGMENT_SLOTS);

    t_state r_state, n_state;

    logic [AW-1:0] r_oldest, n_oldest;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic [31:0]   r_seq, n_seq;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_rd_left, n_rd_left;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_cmp_slot, n_cmp_slot;

    logic [1:0]    r_res_status, n_res_status;
    logic [AW-1:0] r_res_slot, n_res_slot;
    logic [2:0]    r_res_kind, n_res_kind;
    logic [31:0]   r_res_handle, n_res_handle;
    logic [31:0]   r_res_off, n_res_off;
    logic [31:0]   r_res_len, n_res_len;

    logic r_rsp_valid, n_rsp_valid;
    t_rsp r_rsp, n_rsp;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_seg          wr_data;
    t_seg          rd_data;

    logic          accept;
    logic          rsp_free;
    logic [31:0]   cmp_off;
    logic          hit;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    sslt_seg_ram #(
        .DEPTH (SEGMENT_SLOTS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign wr_data = '{start: i_req.seq, length: i_req.length,
                       kind: i_req.kind, token: i_req.handle};

    assign accept   = (r_state == S_IDLE) && i_req_valid;
    assign rsp_free = !r_rsp_valid || !i_rsp_stall;

    // shared compare unit: wrap-aware range test against the segment just read
    assign cmp_off = r_seq - rd_data.start;
    assign hit     = r_pend && (cmp_off < rd_data.length);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.command == CMD_LOOKUP && r_count != '0) begin
                        n_state = S_SCAN;
                    end else if (i_req.command == CMD_RETIRE && r_count != '0) begin
                        n_state = S_RET;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_SCAN: begin
                if (hit || r_rd_left == '0) begin
                    n_state = S_PUSH;
                end
            end
            S_RET: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_req_stall  = (r_state != S_IDLE);
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_rd_ptr;
        n_oldest     = r_oldest;
        n_tail       = r_tail;
        n_count      = r_count;
        n_seq        = r_seq;
        n_rd_ptr     = r_rd_ptr;
        n_rd_left    = r_rd_left;
        n_pend       = r_pend;
        n_cmp_slot   = r_cmp_slot;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_kind   = r_res_kind;
        n_res_handle = r_res_handle;
        n_res_off    = r_res_off;
        n_res_len    = r_res_len;
        n_rsp_valid  = r_rsp_valid && i_rsp_stall;
        n_rsp        = r_rsp;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_seq        = i_req.seq;
                    n_res_status = ST_MISS;
                    n_res_slot   = '0;
                    n_res_kind   = '0;
                    n_res_handle = '0;
                    n_res_off    = '0;
                    n_res_len    = '0;
                    case (i_req.command)
                        CMD_ATTACH: begin
                            if (r_count == FULL_CNT) begin
                                n_res_status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                n_res_status = ST_OK;
                                n_res_slot   = r_tail;
                                n_tail       = slot_inc(r_tail);
                                n_count      = r_count + 1'b1;
                            end
                        end
                        CMD_LOOKUP: begin
                            n_rd_ptr  = r_oldest;
                            n_rd_left = r_count;
                            n_pend    = 1'b0;
                        end
                        CMD_RETIRE: begin
                            if (r_count != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = r_oldest;
                                n_cmp_slot = r_oldest;
                                n_oldest   = slot_inc(r_oldest);
                                n_count    = r_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // overlap the next read with the compare of the previous one
                rd_en      = (r_rd_left != '0);
                n_pend     = rd_en;
                n_cmp_slot = r_rd_ptr;
                if (rd_en) begin
                    n_rd_ptr  = slot_inc(r_rd_ptr);
                    n_rd_left = r_rd_left - 1'b1;
                end
                if (hit) begin
                    n_res_status = ST_OK;
                    n_res_slot   = r_cmp_slot;
                    n_res_kind   = rd_data.kind;
                    n_res_handle = rd_data.token;
                    n_res_off    = cmp_off;
                    n_res_len    = rd_data.length;
                end
            end
            S_RET: begin
                n_res_status = ST_OK;
                n_res_slot   = r_cmp_slot;
                n_res_kind   = rd_data.kind;
                n_res_handle = rd_data.token;
            end
            S_PUSH: begin
                if (rsp_free) begin
                    n_rsp_valid        = 1'b1;
                    n_rsp.status       = r_res_status;
                    n_rsp.slot         = SLOT_OUT_W'(r_res_slot);
                    n_rsp.found_kind   = r_res_kind;
                    n_rsp.found_handle = r_res_handle;
                    n_rsp.offset       = r_res_off;
                    n_rsp.remaining    = r_res_len - r_res_off;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rd_left   <= '0;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_rd_left   <= n_rd_left;
            r_pend      <= n_pend;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq        <= n_seq;
        r_rd_ptr     <= n_rd_ptr;
        r_cmp_slot   <= n_cmp_slot;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_kind   <= n_res_kind;
        r_res_handle <= n_res_handle;
        r_res_off    <= n_res_off;
        r_res_len    <= n_res_len;
        r_rsp        <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("segment count above capacity");

    a_empty_ring : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_tail == r_oldest)
        else $error("empty ring with tail away from oldest");

    a_count_at_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> $past(r_state) == S_IDLE)
        else $error("segment count changed outside request acceptance");

    a_rsp_from_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state) == S_PUSH)
        else $error("response raised outside push state");

endmodule

`default_nettype wire

FILE: hdl/sslt_seg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sslt_seg_ram
    import sslt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_seg          i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_seg               o_rd_data
);

    t_seg r_mem [DEPTH];
    t_seg r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: tb/send_segment_seq_lookup_table_tb.sv
`timescale 1ns / 1ps

module send_segment_seq_lookup_table_tb;
    import sslt_pkg::*;

    localparam int SLOTS = 64;
    localparam int ITEMS = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int unsigned LIMIT = 600_000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Two copies of the ring: one follows accepted requests, one plans stimulus
    localparam int CHK = 0;
    localparam int PLAN = 1;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b1;
    t_rsp rsp;

    logic [31:0] seg_start [2][SLOTS];
    logic [31:0] seg_length [2][SLOTS];
    logic [2:0] seg_kind [2][SLOTS];
    logic [31:0] seg_token [2][SLOTS];
    int unsigned ring_head [2];
    int unsigned ring_fill [2];

    t_req request_q[$];
    t_rsp due_results[$];
    int planned;
    logic req_fire = 1'b0;

    int mismatches;
    int results_seen;
    int cnt_ok;
    int cnt_full;
    int cnt_miss;
    int unsigned cycle_count;

    send_segment_seq_lookup_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_rsp segment_ring_step(input int v, input t_req r);
        t_rsp res;
        int unsigned s;
        int unsigned i;
        logic [31:0] off;
        bit hit;
        res = '0;
        res.status = ST_MISS;
        hit = 1'b0;
        case (r.command)
            CMD_ATTACH: begin
                if (ring_fill[v] >= SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    s = (ring_head[v] + ring_fill[v]) % SLOTS;
                    seg_start[v][s] = r.seq;
                    seg_length[v][s] = r.length;
                    seg_kind[v][s] = r.kind;
                    seg_token[v][s] = r.handle;
                    ring_fill[v]++;
                    res.status = ST_OK;
                    res.slot = s[SLOT_OUT_W-1:0];
                end
            end
            CMD_LOOKUP: begin
                // oldest first: the first segment that holds the number wins
                for (i = 0; i < ring_fill[v] && !hit; i++) begin
                    s = (ring_head[v] + i) % SLOTS;
                    off = r.seq - seg_start[v][s];
                    if (off < seg_length[v][s]) begin
                        hit = 1'b1;
                        res.status = ST_OK;
                        res.slot = s[SLOT_OUT_W-1:0];
                        res.found_kind = seg_kind[v][s];
                        res.found_handle = seg_token[v][s];
                        res.offset = off;
                        res.remaining = seg_length[v][s] - off;
                    end
                end
            end
            CMD_RETIRE: begin
                if (ring_fill[v] != 0) begin
                    s = ring_head[v];
                    res.status = ST_OK;
                    res.slot = s[SLOT_OUT_W-1:0];
                    res.found_kind = seg_kind[v][s];
                    res.found_handle = seg_token[v][s];
                    ring_head[v] = (s + 1) % SLOTS;
                    ring_fill[v]--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_request(input logic [1:0] cmd, input logic [31:0] sq,
                                 input logic [31:0] ln, input logic [2:0] kd,
                                 input logic [31:0] hd);
        t_req r;
        r.command = cmd;
        r.seq = sq;
        r.length = ln;
        r.kind = kd;
        r.handle = hd;
        request_q.push_back(r);
        void'(segment_ring_step(PLAN, r));
        if (cmd != CMD_UNUSED) planned++;
    endtask

    function automatic logic [31:0] segment_len(input bit allow_huge);
        int unsigned pick;
        pick = $urandom_range(0, 31);
        if (pick == 0) return 32'd0;
        if (allow_huge && pick == 1) return $urandom;
        if (allow_huge && pick == 2) return 32'hFFFF_FFFF;
        return $urandom_range(1, 1460);
    endfunction

    // Aim mostly at live segments and their edges
    function automatic logic [31:0] lookup_target();
        int unsigned pick;
        int unsigned s;
        logic [31:0] st;
        logic [31:0] ln;
        if (ring_fill[PLAN] == 0 || $urandom_range(0, 9) == 0) return $urandom;
        pick = $urandom_range(0, ring_fill[PLAN] - 1);
        s = (ring_head[PLAN] + pick) % SLOTS;
        st = seg_start[PLAN][s];
        ln = seg_length[PLAN][s];
        case ($urandom_range(0, 5))
            0: return st;
            1: return st + ln - 32'd1;
            2: return st + ln;
            3: return st - 32'd1;
            default: return (ln == 0) ? st : st + ($urandom % ln);
        endcase
    endfunction

    task automatic queue_lookup();
        queue_request(CMD_LOOKUP, lookup_target(), $urandom, 3'($urandom_range(0, 7)),
                      $urandom);
    endtask

    task automatic queue_retire();
        queue_request(CMD_RETIRE, $urandom, $urandom, 3'($urandom_range(0, 7)), $urandom);
    endtask

    // Driver: bursts of requests separated by random gaps
    always @(negedge clk) begin : driver
        int gap_left;
        int burst_left;
        if (rst_n && (!req_valid || req_fire)) begin
            if (gap_left > 0) begin
                req_valid <= 1'b0;
                gap_left--;
            end else if (request_q.size() > 0) begin
                req <= request_q.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern changes mode now and then; one long hold-off
    always @(negedge clk) begin : receiver
        int hold_left;
        bit hold_done;
        int mode_left;
        int phase_cnt;
        t_rx_mode mode;
        phase_cnt++;
        if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RX_OPEN: rsp_stall <= 1'b0;
                RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= (phase_cnt % 5) < 2;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : monitor
        t_rsp want;
        if (!rst_n) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= req_valid && !req_stall;
            if (req_valid && !req_stall) due_results.push_back(segment_ring_step(CHK, req));
            if (rsp_valid && !rsp_stall) begin
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d slot %0d",
                           rsp.status, rsp.slot);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    results_seen++;
                    case (want.status)
                        ST_OK: cnt_ok++;
                        ST_FULL: cnt_full++;
                        default: cnt_miss++;
                    endcase
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("slot", 32'(want.slot), 32'(rsp.slot));
                    check_field("found_kind", 32'(want.found_kind), 32'(rsp.found_kind));
                    check_field("found_handle", want.found_handle, rsp.found_handle);
                    check_field("offset", want.offset, rsp.offset);
                    check_field("remaining", want.remaining, rsp.remaining);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     due_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int extra;
        bit huge;
        logic [31:0] next_seq;
        logic [31:0] ln;

        // empty table, unused command, wrapping and zero-length segments
        queue_retire();
        queue_request(CMD_LOOKUP, 32'h0, 32'h0, 3'd0, 32'h0);
        queue_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        queue_request(CMD_ATTACH, 32'hFFFF_FFF0, 32'h20, 3'd0, 32'hFFFF_FFFF);
        queue_request(CMD_ATTACH, 32'h10, 32'h0, 3'd4, 32'h0);
        queue_request(CMD_ATTACH, 32'h10, 32'hFFFF_FFFF, 3'd7, 32'hA5A5_5A5A);
        queue_request(CMD_ATTACH, 32'h0, 32'h1, 3'd3, 32'h1);
        queue_request(CMD_LOOKUP, 32'hFFFF_FFF0, 32'h0, 3'd0, 32'h0);
        queue_request(CMD_LOOKUP, 32'h0000_000F, 32'h0, 3'd0, 32'h0);
        queue_request(CMD_LOOKUP, 32'h10, 32'h0, 3'd0, 32'h0);
        queue_request(CMD_LOOKUP, 32'hFFFF_FFEF, 32'h0, 3'd0, 32'h0);
        queue_retire();
        queue_request(CMD_LOOKUP, 32'h0000_000F, 32'h0, 3'd0, 32'h0);
        queue_request(CMD_LOOKUP, 32'h0, 32'h0, 3'd0, 32'h0);
        queue_retire();
        queue_retire();
        queue_request(CMD_LOOKUP, 32'h0, 32'h0, 3'd0, 32'h0);
        queue_retire();
        queue_retire();
        queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);

        phase = 0;
        while (planned < ITEMS) begin
            next_seq = ($urandom_range(0, 1) == 1) ? $urandom
                     : 32'hFFFF_FFFF - $urandom_range(0, 20000);
            huge = ($urandom_range(0, 3) == 0);
            case (phase % 5)
                0, 2: begin
                    // steady stream: append, look up and retire in mixed order
                    n = $urandom_range(30, 80);
                    repeat (n) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: begin
                                if (ring_fill[PLAN] >= SLOTS - 4) begin
                                    queue_retire();
                                end else begin
                                    ln = segment_len(huge);
                                    if ($urandom_range(0, 19) == 0) next_seq = $urandom;
                                    queue_request(CMD_ATTACH, next_seq, ln,
                                                  3'($urandom_range(0, 4)), $urandom);
                                    next_seq += ln;
                                end
                            end
                            8, 9: queue_retire();
                            default: queue_lookup();
                        endcase
                    end
                end
                1: begin
                    // fill to the top, then push past it
                    while (ring_fill[PLAN] < SLOTS) begin
                        if ($urandom_range(0, 3) == 0) queue_lookup();
                        ln = segment_len(huge);
                        queue_request(CMD_ATTACH, next_seq, ln, 3'($urandom_range(0, 4)),
                                      $urandom);
                        next_seq += ln;
                    end
                    extra = $urandom_range(1, 3);
                    repeat (extra) begin
                        queue_request(CMD_ATTACH, $urandom, $urandom, 3'($urandom_range(0, 7)),
                                      $urandom);
                    end
                    extra = $urandom_range(2, 6);
                    repeat (extra) queue_lookup();
                end
                3: begin
                    // drain to empty, then retire and look up on the empty ring
                    while (ring_fill[PLAN] > 0) begin
                        if ($urandom_range(0, 3) == 0) queue_lookup();
                        queue_retire();
                    end
                    extra = $urandom_range(1, 2);
                    repeat (extra) queue_retire();
                    queue_lookup();
                end
                default: begin
                    n = $urandom_range(8, 16);
                    repeat (n) begin
                        queue_request(2'($urandom_range(0, 3)), $urandom, $urandom,
                                      3'($urandom_range(0, 7)), $urandom);
                    end
                end
            endcase
            phase++;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || req_valid) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests checked in %0d cycles: %0d done or found, %0d full,",
                 results_seen, cycle_count, cnt_ok, cnt_full);
        $display("%0d not found or empty; ring filled and drained, output held off %0d cycles",
                 cnt_miss, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
